FILE: design/eft_pkg.sv
// eft_pkg: shared constants and tables for the Euler frame transform core
// used by the channel interfaces and by euler_frame_transform_core
`timescale 1ns / 1ps

package eft_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int ANGLE_WIDTH_DEF = 16;

    // cordic works on 32-bit binary angles, x/y/z held in 34 bits
    localparam int CORDIC_ITERS = 30;
    localparam int CORDIC_W     = 34;
    localparam int TRIG_W       = 32;
    localparam int BAM_W        = 32;

    localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] ONE_Q30      = 34'sd1073741824;
    localparam logic signed [CORDIC_W-1:0] HALF_TURN    = 34'sd2147483648;
    localparam logic signed [63:0]         HALF_Q30     = 64'sd536870912;

    // arctangent of 2^-i in 32-bit binary angle units
    function automatic logic signed [CORDIC_W-1:0] atan_unit(input int idx);
        logic signed [CORDIC_W-1:0] a;
        case (idx)
            0:       a = 34'sd536870912;
            1:       a = 34'sd316933406;
            2:       a = 34'sd167458907;
            3:       a = 34'sd85004756;
            4:       a = 34'sd42667331;
            5:       a = 34'sd21354465;
            6:       a = 34'sd10679838;
            7:       a = 34'sd5340245;
            8:       a = 34'sd2670163;
            9:       a = 34'sd1335087;
            10:      a = 34'sd667544;
            11:      a = 34'sd333772;
            12:      a = 34'sd166886;
            13:      a = 34'sd83443;
            14:      a = 34'sd41722;
            15:      a = 34'sd20861;
            16:      a = 34'sd10430;
            17:      a = 34'sd5215;
            18:      a = 34'sd2608;
            19:      a = 34'sd1304;
            20:      a = 34'sd652;
            21:      a = 34'sd326;
            22:      a = 34'sd163;
            23:      a = 34'sd81;
            24:      a = 34'sd41;
            25:      a = 34'sd20;
            26:      a = 34'sd10;
            27:      a = 34'sd5;
            28:      a = 34'sd3;
            29:      a = 34'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

FILE: design/eft_in_if.sv
// eft_in_if: input channel of the Euler frame transform core
// depends on eft_pkg for default widths
`timescale 1ns / 1ps

interface eft_in_if #(
    parameter int COORD_WIDTH = eft_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = eft_pkg::ANGLE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic        [ANGLE_WIDTH-1:0] roll;
    logic        [ANGLE_WIDTH-1:0] pitch;
    logic        [ANGLE_WIDTH-1:0] yaw;
    logic signed [COORD_WIDTH-1:0] pt_x;
    logic signed [COORD_WIDTH-1:0] pt_y;
    logic signed [COORD_WIDTH-1:0] pt_z;

    modport source (
        output valid, kind, pos_x, pos_y, pos_z, roll, pitch, yaw, pt_x, pt_y, pt_z,
        input  ready
    );

    modport sink (
        input  valid, kind, pos_x, pos_y, pos_z, roll, pitch, yaw, pt_x, pt_y, pt_z,
        output ready
    );
endinterface

FILE: design/eft_out_if.sv
// eft_out_if: result channel of the Euler frame transform core
// depends on eft_pkg for default widths
`timescale 1ns / 1ps

interface eft_out_if #(
    parameter int COORD_WIDTH = eft_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          saturated;

    modport source (
        output valid, out_x, out_y, out_z, saturated,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_z, saturated,
        output ready
    );
endinterface

FILE: design/euler_frame_transform_core.sv
// euler_frame_transform_core: pipelined zyx Euler rigid frame transform
// depends on eft_pkg, eft_in_if and eft_out_if
`timescale 1ns / 1ps

// Usage
//   ingress: one transaction carries kind, body position, roll/pitch/yaw
//   binary angles and a point. kind 0 maps world to local, R * (pt - pos);
//   kind 1 maps local to world, R^T * pt + pos.
//   egress: one transaction per input transaction, in order, with the
//   saturated point and a flag set when any coordinate was clipped.
// Pipeline
//   from acceptance to egress.valid a transaction passes one capture
//   stage, 30 cordic iteration stages (three angles side by side), clamp,
//   two multiply stages for the matrix products, matrix sum, split dot
//   product multiply, partial sum, rounding and the output register.
//   one transaction per cycle unless stalled; every stage is a register.
// Reset
//   rst_n clears all stage valid bits; the pipeline comes up empty.
// Stall
//   when egress.ready is low with a result waiting, the whole pipeline
//   holds and ingress.ready drops; no transaction is lost or repeated.

module euler_frame_transform_core #(
    parameter int COORD_WIDTH = eft_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = eft_pkg::ANGLE_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    eft_in_if.sink       ingress,
    eft_out_if.source    egress
);

    localparam int ITERS  = eft_pkg::CORDIC_ITERS;
    localparam int XW     = eft_pkg::CORDIC_W;
    localparam int TW_TRIG = eft_pkg::TRIG_W;
    localparam int BW     = eft_pkg::BAM_W;

    // stage indexes
    localparam int ST_CLAMP  = ITERS + 1;
    localparam int ST_MAT    = ITERS + 4;
    localparam int ST_TOT    = ITERS + 7;
    localparam int ST_OUT    = ITERS + 8;
    localparam int NV        = ST_OUT + 1;

    // arithmetic widths
    localparam int MW   = TW_TRIG + 1;
    localparam int VW   = COORD_WIDTH + 1;
    localparam int H    = VW / 2;
    localparam int VHW  = VW - H;
    localparam int PHW  = MW + VHW;
    localparam int PLW  = MW + H + 1;
    localparam int HSW  = PHW + 2;
    localparam int LSW  = PLW + 2;
    localparam int ACW  = MW + VW + 3;
    localparam int RW   = ACW - 30;

    localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [TW_TRIG-1:0] ONE_T = TW_TRIG'(eft_pkg::ONE_Q30);

    function automatic logic signed [TW_TRIG-1:0] mul_q30(
        input logic signed [TW_TRIG-1:0] a,
        input logic signed [TW_TRIG-1:0] b
    );
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + eft_pkg::HALF_Q30;
        return TW_TRIG'(p >>> 30);
    endfunction

    // ------------------------------------------------------------------
    // flow control and valid chain
    // ------------------------------------------------------------------
    logic          adv;
    logic [NV-1:0] vld_reg;
    logic [NV-1:0] vld_next;

    assign adv           = !vld_reg[NV-1] || egress.ready;
    assign ingress.ready = adv;
    assign vld_next      = {vld_reg[NV-2:0], ingress.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // ------------------------------------------------------------------
    // payload carried alongside the cordic
    // ------------------------------------------------------------------
    logic                          kind_pipe_reg [0:ST_TOT];
    logic signed [COORD_WIDTH-1:0] pos_pipe_reg  [0:ST_TOT][0:2];
    logic signed [VW-1:0]          v_pipe_reg    [0:ST_MAT][0:2];

    logic signed [COORD_WIDTH-1:0] pos_in [0:2];
    logic signed [COORD_WIDTH-1:0] pt_in  [0:2];
    logic        [ANGLE_WIDTH-1:0] ang_in [0:2];

    assign pos_in[0] = ingress.pos_x;
    assign pos_in[1] = ingress.pos_y;
    assign pos_in[2] = ingress.pos_z;
    assign pt_in[0]  = ingress.pt_x;
    assign pt_in[1]  = ingress.pt_y;
    assign pt_in[2]  = ingress.pt_z;
    assign ang_in[0] = ingress.roll;
    assign ang_in[1] = ingress.pitch;
    assign ang_in[2] = ingress.yaw;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_pipe_reg[0] <= ingress.kind;
            for (int l = 0; l < 3; l++)
            begin
                pos_pipe_reg[0][l] <= pos_in[l];
                // local to world rotates the point itself
                if (ingress.kind)
                    v_pipe_reg[0][l] <= VW'(pt_in[l]);
                else
                    v_pipe_reg[0][l] <= VW'(pt_in[l]) - VW'(pos_in[l]);
            end
            for (int s = 1; s <= ST_TOT; s++)
            begin
                kind_pipe_reg[s] <= kind_pipe_reg[s-1];
                for (int l = 0; l < 3; l++)
                begin
                    pos_pipe_reg[s][l] <= pos_pipe_reg[s-1][l];
                end
            end
            for (int s = 1; s <= ST_MAT; s++)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    v_pipe_reg[s][l] <= v_pipe_reg[s-1][l];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // angle folding into +-quarter turn and cordic iterations
    // ------------------------------------------------------------------
    logic signed [XW-1:0] cx_reg   [0:ITERS][0:2];
    logic signed [XW-1:0] cy_reg   [0:ITERS][0:2];
    logic signed [XW-1:0] cz_reg   [0:ITERS-1][0:2];
    logic                 cneg_reg [0:ITERS][0:2];

    logic signed [XW-1:0] pre_z   [0:2];
    logic                 pre_neg [0:2];

    always_comb
    begin
        logic        [BW-1:0] a32;
        logic signed [XW-1:0] z;
        for (int l = 0; l < 3; l++)
        begin
            a32 = {ang_in[l], {(BW-ANGLE_WIDTH){1'b0}}};
            z   = XW'($signed(a32));
            if (z > eft_pkg::ONE_Q30)
            begin
                pre_z[l]   = z - eft_pkg::HALF_TURN;
                pre_neg[l] = 1'b1;
            end
            else if (z < -eft_pkg::ONE_Q30)
            begin
                pre_z[l]   = z + eft_pkg::HALF_TURN;
                pre_neg[l] = 1'b1;
            end
            else
            begin
                pre_z[l]   = z;
                pre_neg[l] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 3; l++)
            begin
                cx_reg[0][l]   <= eft_pkg::CORDIC_START;
                cy_reg[0][l]   <= '0;
                cz_reg[0][l]   <= pre_z[l];
                cneg_reg[0][l] <= pre_neg[l];
            end
        end
    end

    for (genvar i = 0; i < ITERS; i++)
    begin : g_cordic
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    cneg_reg[i+1][l] <= cneg_reg[i][l];
                    if (cz_reg[i][l] >= 0)
                    begin
                        cx_reg[i+1][l] <= cx_reg[i][l] - (cy_reg[i][l] >>> i);
                        cy_reg[i+1][l] <= cy_reg[i][l] + (cx_reg[i][l] >>> i);
                    end
                    else
                    begin
                        cx_reg[i+1][l] <= cx_reg[i][l] + (cy_reg[i][l] >>> i);
                        cy_reg[i+1][l] <= cy_reg[i][l] - (cx_reg[i][l] >>> i);
                    end
                end
            end
        end

        if (i < ITERS - 1)
        begin : g_angle
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    for (int l = 0; l < 3; l++)
                    begin
                        if (cz_reg[i][l] >= 0)
                        begin
                            cz_reg[i+1][l] <= cz_reg[i][l] - eft_pkg::atan_unit(i);
                        end
                        else
                        begin
                            cz_reg[i+1][l] <= cz_reg[i][l] + eft_pkg::atan_unit(i);
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sign fix and clamp to [-1, 1] in Q30
    // ------------------------------------------------------------------
    logic signed [TW_TRIG-1:0] sin_reg [0:2];
    logic signed [TW_TRIG-1:0] cos_reg [0:2];

    always_ff @(posedge clk)
    begin
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        if (adv)
        begin
            for (int l = 0; l < 3; l++)
            begin
                xs = cneg_reg[ITERS][l] ? -cx_reg[ITERS][l] : cx_reg[ITERS][l];
                ys = cneg_reg[ITERS][l] ? -cy_reg[ITERS][l] : cy_reg[ITERS][l];
                if (xs > eft_pkg::ONE_Q30)
                    cos_reg[l] <= ONE_T;
                else if (xs < -eft_pkg::ONE_Q30)
                    cos_reg[l] <= -ONE_T;
                else
                    cos_reg[l] <= TW_TRIG'(xs);
                if (ys > eft_pkg::ONE_Q30)
                    sin_reg[l] <= ONE_T;
                else if (ys < -eft_pkg::ONE_Q30)
                    sin_reg[l] <= -ONE_T;
                else
                    sin_reg[l] <= TW_TRIG'(ys);
            end
        end
    end

    // ------------------------------------------------------------------
    // rotation matrix: pair products, triple products, entry sums
    // ------------------------------------------------------------------
    logic signed [TW_TRIG-1:0] s1s2_reg, c1s2_reg, c2c3_reg, c2s3_reg, c1s3_reg;
    logic signed [TW_TRIG-1:0] c1c3_reg, s1c2_reg, s1s3_reg, s1c3_reg, c1c2_reg;
    logic signed [TW_TRIG-1:0] s2_p1_reg, s3_p1_reg, c3_p1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1s2_reg  <= mul_q30(sin_reg[0], sin_reg[1]);
            c1s2_reg  <= mul_q30(cos_reg[0], sin_reg[1]);
            c2c3_reg  <= mul_q30(cos_reg[1], cos_reg[2]);
            c2s3_reg  <= mul_q30(cos_reg[1], sin_reg[2]);
            c1s3_reg  <= mul_q30(cos_reg[0], sin_reg[2]);
            c1c3_reg  <= mul_q30(cos_reg[0], cos_reg[2]);
            s1c2_reg  <= mul_q30(sin_reg[0], cos_reg[1]);
            s1s3_reg  <= mul_q30(sin_reg[0], sin_reg[2]);
            s1c3_reg  <= mul_q30(sin_reg[0], cos_reg[2]);
            c1c2_reg  <= mul_q30(cos_reg[0], cos_reg[1]);
            s2_p1_reg <= sin_reg[1];
            s3_p1_reg <= sin_reg[2];
            c3_p1_reg <= cos_reg[2];
        end
    end

    logic signed [TW_TRIG-1:0] t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [TW_TRIG-1:0] c2c3_p2_reg, c2s3_p2_reg, c1s3_p2_reg, c1c3_p2_reg;
    logic signed [TW_TRIG-1:0] s1c2_p2_reg, s1s3_p2_reg, s1c3_p2_reg, c1c2_p2_reg;
    logic signed [TW_TRIG-1:0] s2_p2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg      <= mul_q30(s1s2_reg, c3_p1_reg);
            t2_reg      <= mul_q30(s1s2_reg, s3_p1_reg);
            t3_reg      <= mul_q30(c1s2_reg, c3_p1_reg);
            t4_reg      <= mul_q30(c1s2_reg, s3_p1_reg);
            c2c3_p2_reg <= c2c3_reg;
            c2s3_p2_reg <= c2s3_reg;
            c1s3_p2_reg <= c1s3_reg;
            c1c3_p2_reg <= c1c3_reg;
            s1c2_p2_reg <= s1c2_reg;
            s1s3_p2_reg <= s1s3_reg;
            s1c3_p2_reg <= s1c3_reg;
            c1c2_p2_reg <= c1c2_reg;
            s2_p2_reg   <= s2_p1_reg;
        end
    end

    logic signed [MW-1:0] m_reg [0:2][0:2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg[0][0] <= MW'(c2c3_p2_reg);
            m_reg[0][1] <= MW'(c2s3_p2_reg);
            m_reg[0][2] <= -MW'(s2_p2_reg);
            m_reg[1][0] <= MW'(t1_reg) - MW'(c1s3_p2_reg);
            m_reg[1][1] <= MW'(c1c3_p2_reg) + MW'(t2_reg);
            m_reg[1][2] <= MW'(s1c2_p2_reg);
            m_reg[2][0] <= MW'(s1s3_p2_reg) + MW'(t3_reg);
            m_reg[2][1] <= MW'(t4_reg) - MW'(s1c3_p2_reg);
            m_reg[2][2] <= MW'(c1c2_p2_reg);
        end
    end

    // ------------------------------------------------------------------
    // dot products, each coordinate split into high and low halves
    // ------------------------------------------------------------------
    logic signed [PHW-1:0] phi_reg [0:2][0:2];
    logic signed [PLW-1:0] plo_reg [0:2][0:2];

    always_ff @(posedge clk)
    begin
        logic signed [MW-1:0]  r;
        logic signed [VHW-1:0] vh;
        logic signed [H:0]     vl;
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    // local to world uses the transposed matrix
                    r  = kind_pipe_reg[ST_MAT] ? m_reg[j][i] : m_reg[i][j];
                    vh = VHW'(v_pipe_reg[ST_MAT][j] >>> H);
                    vl = {1'b0, v_pipe_reg[ST_MAT][j][H-1:0]};
                    phi_reg[i][j] <= PHW'(r) * PHW'(vh);
                    plo_reg[i][j] <= PLW'(r) * PLW'(vl);
                end
            end
        end
    end

    logic signed [HSW-1:0] hs_reg [0:2];
    logic signed [LSW-1:0] ls_reg [0:2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                hs_reg[i] <= HSW'(phi_reg[i][0]) + HSW'(phi_reg[i][1]) + HSW'(phi_reg[i][2]);
                ls_reg[i] <= LSW'(plo_reg[i][0]) + LSW'(plo_reg[i][1]) + LSW'(plo_reg[i][2]);
            end
        end
    end

    logic signed [RW-1:0] tot_reg [0:2];

    always_ff @(posedge clk)
    begin
        logic signed [ACW-1:0] acc;
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                // round half up, floor by 2^30
                acc = (ACW'(hs_reg[i]) <<< H) + ACW'(ls_reg[i]) + ACW'(eft_pkg::HALF_Q30);
                tot_reg[i] <= RW'(acc >>> 30);
            end
        end
    end

    // ------------------------------------------------------------------
    // position add (local to world only), saturation and output register
    // ------------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] res_reg [0:2];
    logic                          sat_reg;

    always_ff @(posedge clk)
    begin
        logic signed [RW:0] sum;
        logic               any_sat;
        if (adv)
        begin
            any_sat = 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                sum = (RW+1)'(tot_reg[i]);
                if (kind_pipe_reg[ST_TOT])
                    sum = sum + (RW+1)'(pos_pipe_reg[ST_TOT][i]);
                if (sum > (RW+1)'(CMAX))
                begin
                    res_reg[i] <= CMAX;
                    any_sat = 1'b1;
                end
                else if (sum < (RW+1)'(CMIN))
                begin
                    res_reg[i] <= CMIN;
                    any_sat = 1'b1;
                end
                else
                begin
                    res_reg[i] <= COORD_WIDTH'(sum);
                end
            end
            sat_reg <= any_sat;
        end
    end

    assign egress.valid     = vld_reg[ST_OUT];
    assign egress.out_x     = res_reg[0];
    assign egress.out_y     = res_reg[1];
    assign egress.out_z     = res_reg[2];
    assign egress.saturated = sat_reg;

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (ingress.valid && ingress.ready) |=> vld_reg[0])
        else $error("accepted transaction did not enter the pipeline");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("valid chain moved during a stall");

    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_CLAMP] |->
            (sin_reg[0] <= ONE_T && sin_reg[0] >= -ONE_T &&
             cos_reg[1] <= ONE_T && cos_reg[1] >= -ONE_T &&
             sin_reg[2] <= ONE_T && cos_reg[2] >= -ONE_T))
        else $error("sine or cosine outside unit range");

    a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (egress.valid && egress.saturated) |->
            (res_reg[0] == CMAX || res_reg[0] == CMIN ||
             res_reg[1] == CMAX || res_reg[1] == CMIN ||
             res_reg[2] == CMAX || res_reg[2] == CMIN))
        else $error("saturated flag without a clipped coordinate");
`endif

endmodule
